// ----- src/hashed_timer_wheel_macros.svh -----
// assertion macros for the timer wheel top level
// no dependencies; included by the top level, the only file that carries assertions
`ifndef HASHED_TIMER_WHEEL_MACROS_SVH
`define HASHED_TIMER_WHEEL_MACROS_SVH

// same-cycle implication, disabled during reset
`define HTW_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("timer wheel check failed");

// next-cycle implication, disabled during reset
`define HTW_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("timer wheel check failed");

`endif

// ----- src/htw_pkg.sv -----
// shared constants, codes and types for the hashed timer wheel
// no dependencies
package htw_pkg;

    localparam int SLOTS        = 64;   // power of two
    localparam int TICK_MSEC    = 10;
    localparam int TIMERS       = 64;
    localparam int MSEC_PER_SEC = 1000;

    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int TIMER_W  = $clog2(TIMERS);
    localparam int LINK_W   = TIMER_W + 1;      // top bit marks end of list
    localparam int COUNT_W  = $clog2(TIMERS + 1);
    localparam int SEC_W    = 10;
    localparam int MSEC_W   = 10;
    localparam int PERIOD_W = 20;
    localparam int INFO_W   = 1 + 2 * SLOT_W;   // persistent, offset, home

    // reciprocal divide by the tick length, one correction step
    localparam int DIV_SHIFT = 23;
    localparam int DIV_MULT  = (1 << DIV_SHIFT) / TICK_MSEC;
    localparam int MULT_W    = $clog2(DIV_MULT + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(TIMERS);

    typedef enum logic [1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_TICK = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_EXPIRED = 2'd1,
        KIND_EMPTY   = 2'd2,
        KIND_RSVD    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ON_WHEEL   = 2'd1,
        ST_BAD_PERIOD = 2'd2,
        ST_BAD_OPTION = 2'd3
    } status_t;

    localparam logic [1:0] OPT_ONESHOT    = 2'd0;
    localparam logic [1:0] OPT_PERSISTENT = 2'd1;

    // result of the period check
    typedef struct packed {
        logic              bad_period;
        logic [SLOT_W-1:0] offset;
    } period_chk_t;

endpackage

// ----- src/htw_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module htw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- src/htw_period.sv -----
// two-stage period check: builds the period in ms, divides by the tick
// depends on htw_pkg; the result is combinational from the second-stage registers
module htw_period (
    input  logic                              aclk,
    input  logic [htw_pkg::SEC_W-1:0]         period_sec,
    input  logic [htw_pkg::MSEC_W-1:0]        period_msec,
    input  logic [htw_pkg::PERIOD_W-1:0]      max_period_ms,
    output htw_pkg::period_chk_t              chk
);

    localparam int PROD_W = htw_pkg::PERIOD_W + htw_pkg::MULT_W;

    logic [htw_pkg::PERIOD_W-1:0] period_reg;
    logic [htw_pkg::PERIOD_W-1:0] period2_reg;
    logic [htw_pkg::PERIOD_W-1:0] quot_reg;
    logic [PROD_W-1:0]            prod;
    logic [htw_pkg::PERIOD_W-1:0] rem;
    logic                         over;
    logic [htw_pkg::PERIOD_W-1:0] quot_fix;

    assign prod = PROD_W'(period_reg) * PROD_W'(htw_pkg::DIV_MULT);

    // stage one: seconds to ms; stage two: estimated quotient
    always_ff @(posedge aclk) begin
        period_reg  <= htw_pkg::PERIOD_W'(period_sec) *
                       htw_pkg::PERIOD_W'(htw_pkg::MSEC_PER_SEC) +
                       htw_pkg::PERIOD_W'(period_msec);
        period2_reg <= period_reg;
        quot_reg    <= htw_pkg::PERIOD_W'(prod >> htw_pkg::DIV_SHIFT);
    end

    // the estimate is low by at most one
    always_comb begin
        rem      = period2_reg - quot_reg * htw_pkg::PERIOD_W'(htw_pkg::TICK_MSEC);
        over     = (rem >= htw_pkg::PERIOD_W'(htw_pkg::TICK_MSEC));
        quot_fix = over ? quot_reg + 1'b1 : quot_reg;
        chk.bad_period = (period2_reg == '0) ||
                         (over ? (rem != htw_pkg::PERIOD_W'(htw_pkg::TICK_MSEC))
                               : (rem != '0)) ||
                         (period2_reg > max_period_ms);
        chk.offset = quot_fix[htw_pkg::SLOT_W-1:0];
    end

endmodule

// ----- src/hashed_timer_wheel.sv -----
// hashed timer wheel top level: sequencer, list memories, result register
// depends on htw_pkg, htw_ram, htw_period and hashed_timer_wheel_macros.svh
//
// Single-level timing wheel of 64 slots holding FIFO lists of 64 timers.
// One word is taken at a time. An add runs through the two-stage period
// check and then appends, with one more write state when the target slot
// already holds timers; a delete unlinks the timer when it is on the
// wheel; a tick walks the slot list, dropping each expired one-shot timer
// and re-appending each persistent one. A result waits until the output
// register is free. The list memories each have one read and one write
// port, and their read data is registered. Each
// result is held in an output register, so the next word is taken while
// a result waits. max_period_ms is written through the cfg port; the
// user must write it only while the block is idle, as the block itself
// does not enforce this.
`include "hashed_timer_wheel_macros.svh"

module hashed_timer_wheel (
    input  logic        aclk,
    input  logic        aresetn,
    // config write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [19:0] cfg_data,      // max_period_ms
    // command words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,       // timer_id, period_sec, period_msec, option
    input  logic [1:0]  s_tuser,       // mode
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,       // status, expired_id, active_count
    output logic [1:0]  m_tuser,       // kind
    output logic        m_tlast
);

    localparam int SW = htw_pkg::SLOT_W;
    localparam int TW = htw_pkg::TIMER_W;
    localparam int LW = htw_pkg::LINK_W;
    localparam int CW = htw_pkg::COUNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD_MUL, S_ADD_DIV, S_ADD_CHK, S_DEL_W,
        S_TK_HEAD, S_TK_PROC, S_APP_W1, S_APP_W2, S_EMIT
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                      mode_reg, mode_next;
    logic [TW-1:0]                   id_reg, id_next;
    logic [htw_pkg::SEC_W-1:0]       sec_reg, sec_next;
    logic [htw_pkg::MSEC_W-1:0]      msec_reg, msec_next;
    logic [1:0]                      opt_reg, opt_next;
    logic [htw_pkg::PERIOD_W-1:0]    maxp_reg, maxp_next;
    logic [SW-1:0]                   cur_reg, cur_next;
    logic [CW-1:0]                   count_reg, count_next;
    logic [htw_pkg::TIMERS-1:0]      on_wheel_reg, on_wheel_next;
    logic [htw_pkg::SLOTS-1:0]       hvld_reg, hvld_next;
    logic [SW-1:0]                   app_slot_reg, app_slot_next;
    logic [TW-1:0]                   app_id_reg, app_id_next;
    logic                            app_pers_reg, app_pers_next;
    logic [SW-1:0]                   app_off_reg, app_off_next;
    logic [TW-1:0]                   tail_reg, tail_next;
    logic [LW-1:0]                   walk_reg, walk_next;
    logic [LW-1:0]                   wnext_reg, wnext_next;
    logic [1:0]                      res_kind_reg, res_kind_next;
    logic [1:0]                      res_status_reg, res_status_next;
    logic [TW-1:0]                   res_id_reg, res_id_next;
    logic                            res_last_reg, res_last_next;
    logic                            m_valid_reg, m_valid_next;
    logic [15:0]                     m_data_reg, m_data_next;
    logic [1:0]                      m_user_reg, m_user_next;
    logic                            m_last_reg, m_last_next;

    // memory ports
    logic                     head_we, tail_we, next_we, prev_we, info_we;
    logic [SW-1:0]            head_waddr, head_raddr, tail_waddr, tail_raddr;
    logic [TW-1:0]            head_wdata, head_rdata, tail_wdata, tail_rdata;
    logic [TW-1:0]            next_waddr, next_raddr, prev_waddr, prev_raddr;
    logic [TW-1:0]            info_waddr, info_raddr;
    logic [LW-1:0]            next_wdata, next_rdata, prev_wdata, prev_rdata;
    logic [htw_pkg::INFO_W-1:0] info_wdata, info_rdata;

    htw_pkg::period_chk_t chk;

    logic              accept, out_free, app_done, had_tail;
    logic [TW-1:0]     s_id;
    logic [SW-1:0]     info_off, info_home, tk_slot;
    logic              info_pers;
    logic [LW-1:0]     dp, dn;

    assign s_id      = s_tdata[5:0];
    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;

    assign info_pers = info_rdata[2*SW];
    assign info_off  = info_rdata[2*SW-1:SW];
    assign info_home = info_rdata[SW-1:0];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // list memories
    htw_ram #(.WIDTH(TW), .DEPTH(htw_pkg::SLOTS)) u_head (
        .aclk(aclk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    htw_ram #(.WIDTH(TW), .DEPTH(htw_pkg::SLOTS)) u_tail (
        .aclk(aclk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
        .raddr(tail_raddr), .rdata(tail_rdata));
    htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::TIMERS)) u_next (
        .aclk(aclk), .we(next_we), .waddr(next_waddr), .wdata(next_wdata),
        .raddr(next_raddr), .rdata(next_rdata));
    htw_ram #(.WIDTH(LW), .DEPTH(htw_pkg::TIMERS)) u_prev (
        .aclk(aclk), .we(prev_we), .waddr(prev_waddr), .wdata(prev_wdata),
        .raddr(prev_raddr), .rdata(prev_rdata));
    htw_ram #(.WIDTH(htw_pkg::INFO_W), .DEPTH(htw_pkg::TIMERS)) u_info (
        .aclk(aclk), .we(info_we), .waddr(info_waddr), .wdata(info_wdata),
        .raddr(info_raddr), .rdata(info_rdata));

    // period check pipeline
    htw_period u_period (
        .aclk(aclk), .period_sec(sec_reg), .period_msec(msec_reg),
        .max_period_ms(maxp_reg), .chk(chk));

    // sequencer
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        id_next         = id_reg;
        sec_next        = sec_reg;
        msec_next       = msec_reg;
        opt_next        = opt_reg;
        maxp_next       = maxp_reg;
        cur_next        = cur_reg;
        count_next      = count_reg;
        on_wheel_next   = on_wheel_reg;
        hvld_next       = hvld_reg;
        app_slot_next   = app_slot_reg;
        app_id_next     = app_id_reg;
        app_pers_next   = app_pers_reg;
        app_off_next    = app_off_reg;
        tail_next       = tail_reg;
        walk_next       = walk_reg;
        wnext_next      = wnext_reg;
        res_kind_next   = res_kind_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_last_next   = res_last_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;

        head_we = 1'b0; head_waddr = '0; head_wdata = '0; head_raddr = '0;
        tail_we = 1'b0; tail_waddr = '0; tail_wdata = '0; tail_raddr = '0;
        next_we = 1'b0; next_waddr = '0; next_wdata = '0; next_raddr = '0;
        prev_we = 1'b0; prev_waddr = '0; prev_wdata = '0; prev_raddr = '0;
        info_we = 1'b0; info_waddr = '0; info_wdata = '0; info_raddr = '0;

        app_done = 1'b0;
        had_tail = hvld_reg[app_slot_reg];
        tk_slot  = cur_reg + info_off;
        dp       = prev_rdata;
        dn       = next_rdata;

        // output register drains
        if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready) begin
            maxp_next = cfg_data;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    mode_next = s_tuser;
                    id_next   = s_id;
                    sec_next  = s_tdata[15:6];
                    msec_next = s_tdata[25:16];
                    opt_next  = s_tdata[27:26];
                    unique case (s_tuser)
                        htw_pkg::MODE_ADD: begin
                            state_next = S_ADD_MUL;
                        end
                        htw_pkg::MODE_DEL: begin
                            next_raddr = s_id;
                            prev_raddr = s_id;
                            info_raddr = s_id;
                            if (on_wheel_reg[s_id]) begin
                                state_next = S_DEL_W;
                            end else begin
                                res_kind_next   = htw_pkg::KIND_STATUS;
                                res_status_next = htw_pkg::ST_OK;
                                res_id_next     = '0;
                                res_last_next   = 1'b1;
                                state_next      = S_EMIT;
                            end
                        end
                        htw_pkg::MODE_TICK: begin
                            cur_next   = cur_reg + 1'b1;
                            head_raddr = cur_reg + 1'b1;
                            state_next = S_TK_HEAD;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_ADD_MUL: state_next = S_ADD_DIV;
            S_ADD_DIV: state_next = S_ADD_CHK;

            // add checks in priority order, then start the append
            S_ADD_CHK: begin
                res_kind_next = htw_pkg::KIND_STATUS;
                res_id_next   = '0;
                res_last_next = 1'b1;
                if (on_wheel_reg[id_reg]) begin
                    res_status_next = htw_pkg::ST_ON_WHEEL;
                    state_next      = S_EMIT;
                end else if (chk.bad_period) begin
                    res_status_next = htw_pkg::ST_BAD_PERIOD;
                    state_next      = S_EMIT;
                end else if (opt_reg != htw_pkg::OPT_ONESHOT &&
                             opt_reg != htw_pkg::OPT_PERSISTENT) begin
                    res_status_next = htw_pkg::ST_BAD_OPTION;
                    state_next      = S_EMIT;
                end else begin
                    res_status_next = htw_pkg::ST_OK;
                    app_slot_next   = cur_reg + chk.offset;
                    app_id_next     = id_reg;
                    app_pers_next   = (opt_reg == htw_pkg::OPT_PERSISTENT);
                    app_off_next    = chk.offset;
                    tail_raddr      = cur_reg + chk.offset;
                    state_next      = S_APP_W1;
                end
            end

            // unlink: neighbors' links, head and tail of the home slot
            S_DEL_W: begin
                if (dp != htw_pkg::NIL) begin
                    next_we    = 1'b1;
                    next_waddr = dp[TW-1:0];
                    next_wdata = dn;
                end else if (dn != htw_pkg::NIL) begin
                    head_we              = 1'b1;
                    head_waddr           = info_home;
                    head_wdata           = dn[TW-1:0];
                    hvld_next[info_home] = 1'b1;
                end else begin
                    hvld_next[info_home] = 1'b0;
                end
                if (dn != htw_pkg::NIL) begin
                    prev_we    = 1'b1;
                    prev_waddr = dn[TW-1:0];
                    prev_wdata = dp;
                end else if (dp != htw_pkg::NIL) begin
                    tail_we    = 1'b1;
                    tail_waddr = info_home;
                    tail_wdata = dp[TW-1:0];
                end
                on_wheel_next[id_reg] = 1'b0;
                count_next            = count_reg - 1'b1;
                res_kind_next         = htw_pkg::KIND_STATUS;
                res_status_next       = htw_pkg::ST_OK;
                res_id_next           = '0;
                res_last_next         = 1'b1;
                state_next            = S_EMIT;
            end

            // detach the slot list and fetch its first timer
            S_TK_HEAD: begin
                hvld_next[cur_reg] = 1'b0;
                if (hvld_reg[cur_reg]) begin
                    walk_next  = {1'b0, head_rdata};
                    next_raddr = head_rdata;
                    info_raddr = head_rdata;
                    state_next = S_TK_PROC;
                end else begin
                    res_kind_next   = htw_pkg::KIND_EMPTY;
                    res_status_next = htw_pkg::ST_OK;
                    res_id_next     = '0;
                    res_last_next   = 1'b1;
                    state_next      = S_EMIT;
                end
            end

            // expire one timer: re-append or drop it
            S_TK_PROC: begin
                wnext_next      = next_rdata;
                res_kind_next   = htw_pkg::KIND_EXPIRED;
                res_status_next = htw_pkg::ST_OK;
                res_id_next     = walk_reg[TW-1:0];
                res_last_next   = (next_rdata == htw_pkg::NIL);
                if (info_pers) begin
                    app_slot_next = tk_slot;
                    app_id_next   = walk_reg[TW-1:0];
                    app_pers_next = 1'b1;
                    app_off_next  = info_off;
                    tail_raddr    = tk_slot;
                    state_next    = S_APP_W1;
                end else begin
                    on_wheel_next[walk_reg[TW-1:0]] = 1'b0;
                    count_next = count_reg - 1'b1;
                    state_next = S_EMIT;
                end
            end

            // append: own links, info, tail, head when the slot is empty
            S_APP_W1: begin
                next_we    = 1'b1;
                next_waddr = app_id_reg;
                next_wdata = htw_pkg::NIL;
                prev_we    = 1'b1;
                prev_waddr = app_id_reg;
                prev_wdata = had_tail ? {1'b0, tail_rdata} : htw_pkg::NIL;
                info_we    = 1'b1;
                info_waddr = app_id_reg;
                info_wdata = {app_pers_reg, app_off_reg, app_slot_reg};
                tail_we    = 1'b1;
                tail_waddr = app_slot_reg;
                tail_wdata = app_id_reg;
                tail_next  = tail_rdata;
                if (had_tail) begin
                    state_next = S_APP_W2;
                end else begin
                    head_we                 = 1'b1;
                    head_waddr              = app_slot_reg;
                    head_wdata              = app_id_reg;
                    hvld_next[app_slot_reg] = 1'b1;
                    app_done                = 1'b1;
                end
            end

            // link the old tail to the new timer
            S_APP_W2: begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                next_wdata = {1'b0, app_id_reg};
                app_done   = 1'b1;
            end

            // hand the result to the output register
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, count_reg, res_id_reg, res_status_reg};
                    m_user_next  = res_kind_reg;
                    m_last_next  = res_last_reg;
                    if (res_last_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        walk_next  = wnext_reg;
                        next_raddr = wnext_reg[TW-1:0];
                        info_raddr = wnext_reg[TW-1:0];
                        state_next = S_TK_PROC;
                    end
                end
            end

            default: state_next = S_IDLE;
        endcase

        // append finished: an add also puts the timer on the wheel
        if (app_done) begin
            if (mode_reg == htw_pkg::MODE_ADD) begin
                on_wheel_next[app_id_reg] = 1'b1;
                count_next = count_reg + 1'b1;
            end
            state_next = S_EMIT;
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            maxp_reg     <= htw_pkg::PERIOD_W'(640);
            cur_reg      <= '0;
            count_reg    <= '0;
            on_wheel_reg <= '0;
            hvld_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            maxp_reg     <= maxp_next;
            cur_reg      <= cur_next;
            count_reg    <= count_next;
            on_wheel_reg <= on_wheel_next;
            hvld_reg     <= hvld_next;
            m_valid_reg  <= m_valid_next;
        end
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        sec_reg        <= sec_next;
        msec_reg       <= msec_next;
        opt_reg        <= opt_next;
        app_slot_reg   <= app_slot_next;
        app_id_reg     <= app_id_next;
        app_pers_reg   <= app_pers_next;
        app_off_reg    <= app_off_next;
        tail_reg       <= tail_next;
        walk_reg       <= walk_next;
        wnext_reg      <= wnext_next;
        res_kind_reg   <= res_kind_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_last_reg   <= res_last_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

    // checks
    `HTW_ASSERT_NOW(a_count_matches, aclk, aresetn, 1'b1,
        count_reg == CW'($countones(on_wheel_reg)))
    `HTW_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1,
        count_reg <= CW'(htw_pkg::TIMERS))
    `HTW_ASSERT_NEXT(a_tick_advances, aclk, aresetn,
        accept && s_tuser == htw_pkg::MODE_TICK,
        cur_reg == SW'($past(cur_reg) + 1'b1))

endmodule

// ----- sim/hashed_timer_wheel_tb.sv -----
// self-checking testbench for the hashed timer wheel: directed table, then random commands
// depends on htw_pkg and the hashed_timer_wheel rtl
`timescale 1ns / 1ps

module hashed_timer_wheel_tb;

    localparam int HOLD_CYCLES = 400;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 40;

    // one expected result word
    typedef struct {
        htw_pkg::kind_t   kind;
        htw_pkg::status_t status;
        logic [5:0]       id;
        logic [6:0]       count;
        logic             last;
    } wheel_result_t;

    // directed row; want_status < 0 means take the status from the predictor
    typedef struct {
        htw_pkg::mode_t mode;
        int             id;
        int             sec;
        int             msec;
        int             opt;
        int             want_status;
    } cmd_row_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [19:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;      // timer_id, period_sec, period_msec, option
    logic [1:0]  s_tuser;      // mode
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;      // status, expired_id, active_count
    logic [1:0]  m_tuser;      // kind
    logic        m_tlast;

    hashed_timer_wheel uut (.*);

    // predictor state: per-slot fifo lists of timer ids
    logic [5:0]    slot_list [htw_pkg::SLOTS][$];
    logic          timer_on [htw_pkg::TIMERS];
    logic          timer_keep [htw_pkg::TIMERS];
    logic [5:0]    timer_off [htw_pkg::TIMERS];
    logic [5:0]    timer_home [htw_pkg::TIMERS];
    logic [5:0]    wheel_pos;
    logic [6:0]    live_timers;
    logic [19:0]   max_period;

    wheel_result_t pending_results [$];
    int            mismatches = 0;
    int            hold_requests = 0;

    // clock
    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // watchdog on cycles with no handshake at all
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("FAIL hashed_timer_wheel");
            $finish;
        end
    end

    // receiver: runs of full throughput, runs of random stalls, long hold on request
    initial begin
        int run_left;
        int hold_left;
        int hold_served;
        bit choppy;
        logic rdy;
        m_tready = 1'b0;
        run_left = 0;
        hold_left = 0;
        hold_served = 0;
        choppy = 0;
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (run_left == 0) begin
                run_left = $urandom_range(40, 5);
                choppy = $urandom_range(1, 0);
            end
            run_left--;
            if (hold_left > 0) begin
                hold_left--;
                rdy = 1'b0;
            end else if (choppy) begin
                rdy = ($urandom_range(3, 0) != 0) ? 1'b0 : 1'b1;
            end else begin
                rdy = 1'b1;
            end
            m_tready <= rdy;
        end
    end

    // result checker
    always @(posedge aclk) begin
        wheel_result_t w;
        logic [1:0] got_status;
        logic [5:0] got_id;
        logic [6:0] got_count;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = m_tdata[1:0];
            got_id     = m_tdata[7:2];
            got_count  = m_tdata[14:8];
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word kind=%0d id=%0d", m_tuser, got_id);
            end else begin
                w = pending_results.pop_front();
                if (m_tuser !== w.kind || got_status !== w.status || got_id !== w.id
                        || got_count !== w.count || m_tlast !== w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp kind=%0d st=%0d id=%0d cnt=%0d last=%0d,",
                                  " got kind=%0d st=%0d id=%0d cnt=%0d last=%0d"},
                            w.kind, w.status, w.id, w.count, w.last,
                            m_tuser, got_status, got_id, got_count, m_tlast);
                end
            end
        end
    end

    function automatic void queue_result(htw_pkg::kind_t k, htw_pkg::status_t st,
                                         logic [5:0] id, logic last);
        wheel_result_t w;
        w.kind = k;
        w.status = st;
        w.id = id;
        w.count = live_timers;
        w.last = last;
        pending_results.push_back(w);
    endfunction

    // work out the results of one accepted command and update the wheel image
    function automatic void predict_wheel(htw_pkg::mode_t mode, logic [5:0] id, int sec,
                                          int msec, int opt, int want_status);
        int period;
        htw_pkg::status_t st;
        logic [5:0] expiring [$];
        logic [5:0] t;
        int where;
        case (mode)
            htw_pkg::MODE_ADD: begin
                // fields are taken at their port widths
                period = (sec & 1023) * htw_pkg::MSEC_PER_SEC + (msec & 1023);
                st = htw_pkg::ST_OK;
                if (timer_on[id])
                    st = htw_pkg::ST_ON_WHEEL;
                else if (period == 0 || period % htw_pkg::TICK_MSEC != 0
                         || period > max_period)
                    st = htw_pkg::ST_BAD_PERIOD;
                else if ((opt & 3) > 1)
                    st = htw_pkg::ST_BAD_OPTION;
                if (st == htw_pkg::ST_OK) begin
                    timer_keep[id] = ((opt & 3) == 1);
                    timer_off[id] = 6'((period / htw_pkg::TICK_MSEC) % htw_pkg::SLOTS);
                    timer_home[id] = wheel_pos + timer_off[id];
                    slot_list[timer_home[id]].push_back(id);
                    timer_on[id] = 1'b1;
                    live_timers++;
                end
                if (want_status >= 0)
                    st = htw_pkg::status_t'(want_status);
                queue_result(htw_pkg::KIND_STATUS, st, 6'd0, 1'b1);
            end
            htw_pkg::MODE_DEL: begin
                if (timer_on[id]) begin
                    where = -1;
                    for (int i = 0; i < slot_list[timer_home[id]].size(); i++)
                        if (slot_list[timer_home[id]][i] == id) where = i;
                    slot_list[timer_home[id]].delete(where);
                    timer_on[id] = 1'b0;
                    live_timers--;
                end
                queue_result(htw_pkg::KIND_STATUS, htw_pkg::ST_OK, 6'd0, 1'b1);
            end
            htw_pkg::MODE_TICK: begin
                wheel_pos = wheel_pos + 6'd1;
                expiring = slot_list[wheel_pos];
                slot_list[wheel_pos].delete();
                if (expiring.size() == 0)
                    queue_result(htw_pkg::KIND_EMPTY, htw_pkg::ST_OK, 6'd0, 1'b1);
                foreach (expiring[i]) begin
                    t = expiring[i];
                    if (timer_keep[t]) begin
                        timer_home[t] = wheel_pos + timer_off[t];
                        slot_list[timer_home[t]].push_back(t);
                    end else begin
                        timer_on[t] = 1'b0;
                        live_timers--;
                    end
                    queue_result(htw_pkg::KIND_EXPIRED, htw_pkg::ST_OK, t,
                                 i == expiring.size() - 1);
                end
            end
            default: ;
        endcase
    endfunction

    // offer one command word and hold it until taken
    task automatic send_cmd(htw_pkg::mode_t mode, int id, int sec, int msec, int opt,
                            int want_status);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {4'b0, opt[1:0], msec[9:0], sec[9:0], id[5:0]};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_wheel(mode, id[5:0], sec, msec, opt, want_status);
    endtask

    task automatic sender_gap(int cycles);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // wait until every expected word has come and the walk has settled
    task automatic drain();
        sender_gap(1);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_max_period(logic [19:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        max_period = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // random command, mostly well-formed adds, deletes and ticks
    task automatic random_cmd();
        int pick;
        int period;
        int top_ticks;
        int sec;
        int msec;
        int opt;
        htw_pkg::mode_t mode;
        pick = $urandom_range(99, 0);
        mode = (pick < 40) ? htw_pkg::MODE_ADD :
               (pick < 58) ? htw_pkg::MODE_DEL :
               (pick < 96) ? htw_pkg::MODE_TICK : htw_pkg::MODE_NOP;
        top_ticks = (max_period / htw_pkg::TICK_MSEC > 200) ? 200
                                                            : max_period / htw_pkg::TICK_MSEC;
        if ($urandom_range(9, 0) < 7 && top_ticks > 0) begin
            period = htw_pkg::TICK_MSEC * $urandom_range(top_ticks, 1);
            if ($urandom_range(7, 0) == 0 && max_period > 100000)
                period = htw_pkg::TICK_MSEC *
                         $urandom_range(max_period / htw_pkg::TICK_MSEC, 1);
            sec = period / htw_pkg::MSEC_PER_SEC;
            msec = period % htw_pkg::MSEC_PER_SEC;
            // same period written with the msec part above one second
            if (sec > 0 && msec < 24 && $urandom_range(1, 0)) begin
                sec--;
                msec += htw_pkg::MSEC_PER_SEC;
            end
        end else begin
            sec = $urandom_range(1023, 0);
            msec = $urandom_range(1023, 0);
            if ($urandom_range(1, 0)) sec = 0;
        end
        opt = ($urandom_range(9, 0) == 0) ? $urandom_range(3, 2) : $urandom_range(1, 0);
        send_cmd(mode, $urandom_range(63, 0), sec, msec, opt, -1);
    endtask

    task automatic random_phase(int items);
        int burst;
        burst = 0;
        repeat (items) begin
            if (burst == 0) begin
                burst = $urandom_range(12, 1);
                if ($urandom_range(1, 0)) sender_gap($urandom_range(15, 1));
            end
            burst--;
            random_cmd();
        end
    endtask

    cmd_row_t directed [] = '{
        '{htw_pkg::MODE_TICK, 0,    0,    0, 0, -1},   // tick on an empty wheel
        '{htw_pkg::MODE_ADD,  0,    0,   10, 0, htw_pkg::ST_OK},
        '{htw_pkg::MODE_ADD,  0,    0,   20, 1, htw_pkg::ST_ON_WHEEL},
        '{htw_pkg::MODE_ADD,  1,    0,    0, 0, htw_pkg::ST_BAD_PERIOD},   // zero period
        '{htw_pkg::MODE_ADD,  1,    0,   15, 0, htw_pkg::ST_BAD_PERIOD},   // not a tick multiple
        '{htw_pkg::MODE_ADD,  1,    0,  650, 0, htw_pkg::ST_BAD_PERIOD},   // above the maximum
        '{htw_pkg::MODE_ADD,  1, 1023, 1023, 3, htw_pkg::ST_BAD_PERIOD},   // period before option
        '{htw_pkg::MODE_ADD,  1,    0,  640, 2, htw_pkg::ST_BAD_OPTION},
        '{htw_pkg::MODE_ADD,  1,    0,  640, 3, htw_pkg::ST_BAD_OPTION},
        '{htw_pkg::MODE_ADD, 63,    0,  640, 1, htw_pkg::ST_OK},   // whole turn, current slot
        '{htw_pkg::MODE_ADD,  2,    0,   20, 1, htw_pkg::ST_OK},
        '{htw_pkg::MODE_ADD,  3,    0,   10, 1, htw_pkg::ST_OK},
        '{htw_pkg::MODE_ADD,  4,    0,   20, 0, htw_pkg::ST_OK},
        '{htw_pkg::MODE_DEL,  5,    0,    0, 0, htw_pkg::ST_OK},   // delete of an idle timer
        '{htw_pkg::MODE_NOP, 63, 1023, 1023, 3, -1},               // ignored
        '{htw_pkg::MODE_TICK, 0,    0,    0, 0, -1},
        '{htw_pkg::MODE_TICK, 0,    0,    0, 0, -1},
        '{htw_pkg::MODE_DEL,  2,    0,    0, 0, htw_pkg::ST_OK},
        '{htw_pkg::MODE_TICK, 0,    0,    0, 0, -1},
        '{htw_pkg::MODE_DEL,  3,    0,    0, 0, htw_pkg::ST_OK},
        '{htw_pkg::MODE_ADD, 10,    0, 1020, 0, htw_pkg::ST_BAD_PERIOD}
    };

    initial begin
        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = htw_pkg::MODE_NOP;
        wheel_pos = '0;
        live_timers = '0;
        max_period = 20'd640;
        foreach (timer_on[i]) begin
            timer_on[i] = 1'b0;
            timer_keep[i] = 1'b0;
            timer_off[i] = '0;
            timer_home[i] = '0;
        end
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table
        foreach (directed[r])
            send_cmd(directed[r].mode, directed[r].id, directed[r].sec,
                     directed[r].msec, directed[r].opt, directed[r].want_status);
        drain();

        // widest period range, long periods at full field values
        write_max_period(20'hFFFFF);
        send_cmd(htw_pkg::MODE_ADD, 20, 1023, 1020, 1, htw_pkg::ST_OK);
        send_cmd(htw_pkg::MODE_ADD, 21, 1, 0, 0, htw_pkg::ST_OK);
        random_phase(60);

        // receiver holds off while commands keep coming
        hold_requests++;
        random_phase(40);
        drain();

        // tightest maximum: every add is refused
        write_max_period(20'd1);
        random_phase(25);
        drain();

        write_max_period(20'(htw_pkg::TICK_MSEC * $urandom_range(100, 2)));
        random_phase(60);
        drain();

        write_max_period(20'd640);
        random_phase(60);
        drain();

        if (mismatches == 0 && pending_results.size() == 0)
            $display("PASS hashed_timer_wheel");
        else
            $display("FAIL hashed_timer_wheel");
        $finish;
    end

endmodule
